// ===== sv/rsau_pkg.sv =====
// Shared types and constants of the RAM / scratchpad access unit.
`default_nettype none

package rsau_pkg;

  // Default store sizes in bytes (powers of two)
  localparam int unsigned MAIN_BYTES_DEF    = 2097152;
  localparam int unsigned SCRATCH_BYTES_DEF = 1024;

  // Masked (29-bit) base of the scratchpad window
  localparam logic [28:0] WIN_BASE = 29'h1F80_0000;

  // Configuration port widths
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    SEG_USER      = 2'd0,
    SEG_KCACHED   = 2'd1,
    SEG_KUNCACHED = 2'd2,
    SEG_KMAPPED   = 2'd3
  } seg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RD_ERR = 2'd1,
    ST_WR_ERR = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SCRATCH_EN_A = 1'b0,
    CFG_SCRATCH_EN_B = 1'b1
  } cfg_idx_e;

  // Routing decision for one item
  typedef struct packed {
    logic    main_rd;
    logic    main_wr;
    logic    sp_rd;
    logic    sp_wr;
    logic    fill;
    status_e status;
  } acc_t;

endpackage

`default_nettype wire

// ===== sv/rsau_req_if.sv =====
// Request channel: one word access per item.
`default_nettype none

interface rsau_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] address;
  logic [1:0]  segment;
  logic [31:0] write_data;

  modport source (output valid, cmd, address, segment, write_data, input ready);
  modport sink   (input valid, cmd, address, segment, write_data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsau_rsp_if.sv =====
// Response channel: read word and status per item.
`default_nettype none

interface rsau_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

`default_nettype wire

// ===== sv/rsau_decode.sv =====
// Address decode: window hit, segment check and store routing.
`default_nettype none

module rsau_decode #(
  parameter int unsigned MAIN_BYTES    = rsau_pkg::MAIN_BYTES_DEF,
  parameter int unsigned SCRATCH_BYTES = rsau_pkg::SCRATCH_BYTES_DEF
) (
  input  wire logic                             cmd_i,
  input  wire logic [31:0]                      address_i,
  input  wire logic [1:0]                       segment_i,
  input  wire logic                             en_a_i,
  input  wire logic                             en_b_i,
  output rsau_pkg::acc_t                        acc_o,
  output logic [$clog2(MAIN_BYTES)-1:0]         main_off_o,
  output logic [$clog2(SCRATCH_BYTES)-1:0]      sp_off_o
);

  localparam int unsigned MAW = $clog2(MAIN_BYTES);
  localparam int unsigned SAW = $clog2(SCRATCH_BYTES);

  logic is_wr;
  logic win;
  logic seg_ok;
  logic sp_on;
  logic to_main;

  // Window base is aligned to the scratchpad size, so the offset is the low bits
  assign is_wr   = rsau_pkg::cmd_e'(cmd_i) == rsau_pkg::CMD_WRITE;
  assign win     = address_i[28:SAW] == rsau_pkg::WIN_BASE[28:SAW];
  assign seg_ok  = (rsau_pkg::seg_e'(segment_i) == rsau_pkg::SEG_USER) ||
                   (rsau_pkg::seg_e'(segment_i) == rsau_pkg::SEG_KCACHED);
  assign sp_on   = en_a_i & en_b_i;
  assign to_main = !win || (seg_ok && !sp_on);

  always_comb begin
    acc_o.main_rd = to_main && !is_wr;
    acc_o.main_wr = to_main && is_wr;
    acc_o.sp_rd   = win && seg_ok && sp_on && !is_wr;
    acc_o.sp_wr   = win && seg_ok && sp_on && is_wr;
    // disabled scratchpad: a read also refills the window
    acc_o.fill    = win && seg_ok && !sp_on && !is_wr;
    if (win && !seg_ok) begin
      acc_o.status = is_wr ? rsau_pkg::ST_WR_ERR : rsau_pkg::ST_RD_ERR;
    end else begin
      acc_o.status = rsau_pkg::ST_OK;
    end
  end

  // Both sizes are powers of two: the wrap is a mask
  assign main_off_o = address_i[MAW-1:0];
  assign sp_off_o   = address_i[SAW-1:0];

endmodule

`default_nettype wire

// ===== sv/rsau_byte_ram.sv =====
// One byte lane of a store: one write port, one registered read port.
`default_nettype none

module rsau_byte_ram #(
  parameter int unsigned DEPTH = rsau_pkg::SCRATCH_BYTES_DEF / 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Read returns the old byte on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ram_scratchpad_access_unit.sv =====
// Top level: word access unit for mirrored main RAM with a scratchpad window.
//
//  port      dir   handshake        payload
//  req_i     in    valid / ready    cmd, address, segment, write_data
//  rsp_o     out   valid / ready    read_data, status
//  cfg_*_i   in    cfg_we_i         cfg_idx_i, cfg_wdata_i (enable bits)
//
// One item per cycle unless stalled; a result passes stage 1, then the output
// register. A read that refills the scratchpad holds req_i.ready low while the
// refill write takes the scratchpad write ports.
// After reset a clearing pass zeroes both stores, one row of four bytes per
// cycle over every main RAM row; no item is taken meanwhile.
// Stores are four byte-wide banks; an unaligned word touches each bank once.
// A stalled result holds the pipeline; the input register waits behind it.
`default_nettype none

module ram_scratchpad_access_unit #(
  parameter int unsigned MAIN_BYTES    = rsau_pkg::MAIN_BYTES_DEF,
  parameter int unsigned SCRATCH_BYTES = rsau_pkg::SCRATCH_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rsau_req_if.sink                           req_i,
  rsau_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rsau_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rsau_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned MAW   = $clog2(MAIN_BYTES);
  localparam int unsigned SAW   = $clog2(SCRATCH_BYTES);
  localparam int unsigned MRW   = MAW - 2;
  localparam int unsigned SRW   = SAW - 2;
  localparam int unsigned MROWS = MAIN_BYTES / 4;
  localparam int unsigned SROWS = SCRATCH_BYTES / 4;

  // Configuration registers
  logic en_a_q;
  logic en_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_a_q <= 1'b0;
      en_b_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (rsau_pkg::cfg_idx_e'(cfg_idx_i))
        rsau_pkg::CFG_SCRATCH_EN_A: en_a_q <= cfg_wdata_i[0];
        rsau_pkg::CFG_SCRATCH_EN_B: en_b_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic           clr_q;
  logic [MRW-1:0] clr_cnt_q;
  logic           clr_last;
  logic           clr_sp;

  assign clr_last = clr_cnt_q == MRW'(MROWS - 1);
  assign clr_sp   = clr_q && (clr_cnt_q < MRW'(SROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + MRW'(1);
      if (clr_last) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Decode of the incoming item
  rsau_pkg::acc_t acc;
  logic [MAW-1:0] main_off;
  logic [SAW-1:0] sp_off;

  rsau_decode #(
    .MAIN_BYTES    (MAIN_BYTES),
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_decode (
    .cmd_i      (req_i.cmd),
    .address_i  (req_i.address),
    .segment_i  (req_i.segment),
    .en_a_i     (en_a_q),
    .en_b_i     (en_b_q),
    .acc_o      (acc),
    .main_off_o (main_off),
    .sp_off_o   (sp_off)
  );

  // Pipeline control
  logic           accept;
  logic           s1_adv;
  logic           s1_valid_q;
  logic           s1_fill_q;
  rsau_pkg::acc_t s1_acc_q;
  logic [1:0]     s1_lane_q;
  logic [SAW-1:0] s1_sp_off_q;
  logic           out_valid_q;
  logic [31:0]    out_data_q;
  logic [1:0]     out_status_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clr_q && !s1_fill_q && (!s1_valid_q || s1_adv);
  assign accept      = req_i.valid && req_i.ready;

  // Byte banks: bank k holds every byte whose offset has k in its low two bits
  logic [7:0] main_rd [4];
  logic [7:0] sp_rd   [4];

  for (genvar gk = 0; gk < 4; gk++) begin : g_bank
    localparam logic [1:0] BANK = 2'(gk);

    logic [1:0]     lane;
    logic [7:0]     wbyte;
    logic [MRW-1:0] m_row;
    logic [SRW-1:0] s_row;
    logic [SRW-1:0] f_row;
    logic           m_we;
    logic [MRW-1:0] m_waddr;
    logic [7:0]     m_wdata;
    logic           s_we;
    logic [SRW-1:0] s_waddr;
    logic [7:0]     s_wdata;

    // Lanes before the start lane wrap into the next row
    assign lane  = BANK - main_off[1:0];
    assign wbyte = req_i.write_data[{lane, 3'b000} +: 8];
    assign m_row = main_off[MAW-1:2] + MRW'(BANK < main_off[1:0]);
    assign s_row = sp_off[SAW-1:2] + SRW'(BANK < sp_off[1:0]);
    assign f_row = s1_sp_off_q[SAW-1:2] + SRW'(BANK < s1_sp_off_q[1:0]);

    // Main bank write: clearing or item write (never both)
    assign m_we    = clr_q || (accept && acc.main_wr);
    assign m_waddr = clr_q ? clr_cnt_q : m_row;
    assign m_wdata = clr_q ? 8'h00 : wbyte;

    rsau_byte_ram #(
      .DEPTH (MROWS)
    ) u_main (
      .clk_i   (clk_i),
      .we_i    (m_we),
      .waddr_i (m_waddr),
      .wdata_i (m_wdata),
      .re_i    (accept && acc.main_rd),
      .raddr_i (m_row),
      .rdata_o (main_rd[gk])
    );

    // Scratch bank write: clearing, refill from main, or item write
    // Refill byte for bank k is main bank k: both offsets share the low bits
    assign s_we = clr_sp || s1_fill_q || (accept && acc.sp_wr);

    always_comb begin
      if (clr_q) begin
        s_waddr = clr_cnt_q[SRW-1:0];
        s_wdata = 8'h00;
      end else if (s1_fill_q) begin
        s_waddr = f_row;
        s_wdata = main_rd[gk];
      end else begin
        s_waddr = s_row;
        s_wdata = wbyte;
      end
    end

    rsau_byte_ram #(
      .DEPTH (SROWS)
    ) u_scratch (
      .clk_i   (clk_i),
      .we_i    (s_we),
      .waddr_i (s_waddr),
      .wdata_i (s_wdata),
      .re_i    (accept && acc.sp_rd),
      .raddr_i (s_row),
      .rdata_o (sp_rd[gk])
    );
  end

  // Stage 1: item whose bank reads are in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fill_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      // refill write happens in the cycle after accept
      s1_fill_q <= accept && acc.fill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_acc_q    <= acc;
      s1_lane_q   <= main_off[1:0];
      s1_sp_off_q <= sp_off;
    end
  end

  // Word assembly: byte i comes from bank (lane + i)
  logic [31:0] rd_word;

  always_comb begin
    logic [1:0] b;
    rd_word = '0;
    for (int i = 0; i < 4; i++) begin
      b = s1_lane_q + 2'(i);
      if (s1_acc_q.sp_rd) begin
        rd_word[8*i +: 8] = sp_rd[b];
      end else if (s1_acc_q.main_rd) begin
        rd_word[8*i +: 8] = main_rd[b];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q   <= rd_word;
      out_status_q <= s1_acc_q.status;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.status    = out_status_q;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !req_i.ready)
    else $error("item accepted during clearing pass");

  a_fill_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fill_q |-> !accept)
    else $error("item accepted while scratchpad refill owns the write ports");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != rsau_pkg::ST_OK)) |-> (out_data_q == 32'h0))
    else $error("region error with nonzero read data");

  a_s1_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !rsp_o.ready) |=> s1_valid_q)
    else $error("stage 1 item dropped under output stall");

endmodule

`default_nettype wire
